// ===== design/lwalu_pkg.sv =====
// ----------------------------------------------------------------------------
// lwalu_pkg
// Shared types, constants and helpers for the longword ALU.
// ----------------------------------------------------------------------------
package lwalu_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned ACTION_W  = 4;
    localparam int unsigned IDX_IN_W  = 4;
    localparam int unsigned NUM_REGS  = 16;
    localparam int unsigned REG_IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    // steps of conditional subtract needed to fold a 4-bit index below NUM_REGS
    localparam int unsigned REDUCE_STEPS = (1 << IDX_IN_W) / NUM_REGS;
    localparam logic [6:0]  NUM_REGS_V   = 7'(NUM_REGS);

    // condition code bit positions
    localparam int unsigned CC_N_BIT = 3;
    localparam int unsigned CC_Z_BIT = 2;
    localparam int unsigned CC_V_BIT = 1;
    localparam int unsigned CC_C_BIT = 0;
    localparam int unsigned CC_W     = 4;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD  = 4'd0,
        ACT_SUB  = 4'd1,
        ACT_OR   = 4'd2,
        ACT_BIC  = 4'd3,
        ACT_XOR  = 4'd4,
        ACT_MOV  = 4'd5,
        ACT_COM  = 4'd6,
        ACT_CMP  = 4'd7,
        ACT_TST  = 4'd8
    } action_t;

    // ALU outcome for one instruction
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [CC_W-1:0]   cc;
        logic              wr;
        logic              defined;
    } alu_res_t;

    // low 4 bits of an operand field, folded into the register range
    function automatic logic [REG_IDX_W-1:0] reg_index(input logic [DATA_W-1:0] v);
        logic [6:0] i;
        i = {3'b000, v[IDX_IN_W-1:0]};
        for (int k = 0; k < int'(REDUCE_STEPS); k++) begin
            if (i >= NUM_REGS_V) begin
                i = i - NUM_REGS_V;
            end
        end
        return i[REG_IDX_W-1:0];
    endfunction

endpackage

// ===== design/lwalu_instr_if.sv =====
// ----------------------------------------------------------------------------
// lwalu_instr_if
// Instruction request channel: valid/ready plus the instruction fields.
// ----------------------------------------------------------------------------
interface lwalu_instr_if;
    logic                                valid;
    logic                                ready;
    logic [lwalu_pkg::ACTION_W-1:0]      action;
    logic                                src_is_literal;
    logic signed [lwalu_pkg::DATA_W-1:0] src_value;
    logic [lwalu_pkg::IDX_IN_W-1:0]      dst_reg;
    logic                                left_is_literal;
    logic signed [lwalu_pkg::DATA_W-1:0] left_value;

    modport source (
        output valid, action, src_is_literal, src_value, dst_reg,
               left_is_literal, left_value,
        input  ready
    );

    modport sink (
        input  valid, action, src_is_literal, src_value, dst_reg,
               left_is_literal, left_value,
        output ready
    );
endinterface

// ===== design/lwalu_result_if.sv =====
// ----------------------------------------------------------------------------
// lwalu_result_if
// Result request channel: valid/ready plus value, flags and status.
// ----------------------------------------------------------------------------
interface lwalu_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [lwalu_pkg::DATA_W-1:0] result_value;
    logic [lwalu_pkg::CC_W-1:0]          cond_codes;
    logic [lwalu_pkg::DATA_W-1:0]        status_word;
    logic                                reg_written;

    modport source (
        output valid, result_value, cond_codes, status_word, reg_written,
        input  ready
    );

    modport sink (
        input  valid, result_value, cond_codes, status_word, reg_written,
        output ready
    );
endinterface

// ===== design/longword_alu_with_condition_codes_top.sv =====
// ----------------------------------------------------------------------------
// longword_alu_with_condition_codes_top
// 32-bit ALU with a register file, status longword and NZVC flags.
// ----------------------------------------------------------------------------
// Usage:
//   instr  : instruction requests (action, operands, destination register).
//   result : one result request per instruction: value, NZVC flags, the
//            updated status longword and whether a register was written.
//   Both channels use valid/ready; a request moves on an edge where both
//   are high.
// Timing:
//   Two stages. The accept edge captures the instruction and launches the
//   register-file reads (registered RAM read); the edge on which the execute
//   stage advances computes in the ALU, writes the register file and status,
//   and loads the output register. The result request is valid once the
//   output register is loaded; throughput is one instruction per cycle while
//   result.ready stays high. Back-to-back dependencies are covered by a
//   one-entry bypass of the most recent register write.
// Reset:
//   rst_n clears all control state, the status longword and the per-register
//   valid bits, so every register reads as zero until first written. No
//   clearing pass is needed; the block accepts requests right after reset.
// Stall:
//   If result.ready is low the output register holds; the execute stage then
//   holds too and instr.ready drops once both are occupied.
// ----------------------------------------------------------------------------
module longword_alu_with_condition_codes_top (
    input  logic                  clk,
    input  logic                  rst_n,
    lwalu_instr_if.sink           instr,
    lwalu_result_if.source        result
);

    localparam int unsigned DW = lwalu_pkg::DATA_W;
    localparam int unsigned IW = lwalu_pkg::REG_IDX_W;

    // ---------------- handshake ----------------
    logic in_acc;
    logic ex_adv;

    // ---------------- execute stage ----------------
    logic                             ex_vld_reg;
    logic [lwalu_pkg::ACTION_W-1:0]   ex_action_reg;
    logic                             ex_src_lit_reg;
    logic [DW-1:0]                    ex_src_val_reg;
    logic [IW-1:0]                    ex_src_idx_reg;
    logic                             ex_left_lit_reg;   // compare with literal minuend
    logic [DW-1:0]                    ex_left_val_reg;
    logic [IW-1:0]                    ex_b_idx_reg;      // dst, or minuend reg for compare
    logic [IW-1:0]                    ex_dst_idx_reg;

    // ---------------- register file support ----------------
    logic [lwalu_pkg::NUM_REGS-1:0]   reg_vld_reg;       // cleared at reset
    logic                             fwd_vld_reg;       // last write bypass
    logic [IW-1:0]                    fwd_idx_reg;
    logic [DW-1:0]                    fwd_data_reg;
    logic [DW-1:0]                    ram_q_a;
    logic [DW-1:0]                    ram_q_b;
    logic [IW-1:0]                    rd_idx_a;
    logic [IW-1:0]                    rd_idx_b;

    // ---------------- status and output ----------------
    logic [DW-1:0]                    status_reg;
    logic [DW-1:0]                    status_next;
    logic                             out_vld_reg;
    logic [DW-1:0]                    out_value_reg;
    logic [lwalu_pkg::CC_W-1:0]       out_cc_reg;
    logic [DW-1:0]                    out_status_reg;
    logic                             out_wr_reg;

    logic [DW-1:0]                    src_op;
    logic [DW-1:0]                    left_op;
    lwalu_pkg::alu_res_t              alu_res;

    // Execute stage drains when the output register is free or being taken.
    assign ex_adv       = ex_vld_reg && (!out_vld_reg || result.ready);
    assign instr.ready  = !ex_vld_reg || ex_adv;
    assign in_acc       = instr.valid && instr.ready;

    // Read addresses from the incoming request; compare reads its minuend
    // register on port B instead of the destination.
    assign rd_idx_a = lwalu_pkg::reg_index(instr.src_value);
    assign rd_idx_b = (instr.action == lwalu_pkg::ACT_CMP)
                    ? lwalu_pkg::reg_index(instr.left_value)
                    : lwalu_pkg::reg_index({{(DW-lwalu_pkg::IDX_IN_W){1'b0}}, instr.dst_reg});

    lwalu_ram #(
        .WIDTH (DW),
        .DEPTH (lwalu_pkg::NUM_REGS)
    ) u_regfile (
        .clk       (clk),
        .wr_en     (ex_adv && alu_res.wr),
        .wr_addr   (ex_dst_idx_reg),
        .wr_data   (alu_res.value),
        .rd_en_a   (in_acc),
        .rd_addr_a (rd_idx_a),
        .rd_data_a (ram_q_a),
        .rd_en_b   (in_acc),
        .rd_addr_b (rd_idx_b),
        .rd_data_b (ram_q_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_vld_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            ex_vld_reg <= 1'b1;
        end
        else if (ex_adv)
        begin
            ex_vld_reg <= 1'b0;
        end
    end

    // Payload of the execute stage.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            ex_action_reg   <= instr.action;
            ex_src_lit_reg  <= instr.src_is_literal;
            ex_src_val_reg  <= instr.src_value;
            ex_src_idx_reg  <= rd_idx_a;
            ex_left_lit_reg <= (instr.action == lwalu_pkg::ACT_CMP) && instr.left_is_literal;
            ex_left_val_reg <= instr.left_value;
            ex_b_idx_reg    <= rd_idx_b;
            ex_dst_idx_reg  <= lwalu_pkg::reg_index(
                                   {{(DW-lwalu_pkg::IDX_IN_W){1'b0}}, instr.dst_reg});
        end
    end

    // Register read resolve: latest write wins, never-written reads as zero.
    function automatic logic [DW-1:0] reg_read(
        input logic [IW-1:0]                  idx,
        input logic [DW-1:0]                  ram_q,
        input logic                           fv,
        input logic [IW-1:0]                  fidx,
        input logic [DW-1:0]                  fdata,
        input logic [lwalu_pkg::NUM_REGS-1:0] vld
    );
        logic [DW-1:0] r;
        if (fv && (fidx == idx))
        begin
            r = fdata;
        end
        else if (vld[idx])
        begin
            r = ram_q;
        end
        else
        begin
            r = '0;
        end
        return r;
    endfunction

    assign src_op  = ex_src_lit_reg ? ex_src_val_reg
                   : reg_read(ex_src_idx_reg, ram_q_a, fwd_vld_reg, fwd_idx_reg,
                              fwd_data_reg, reg_vld_reg);
    assign left_op = ex_left_lit_reg ? ex_left_val_reg
                   : reg_read(ex_b_idx_reg, ram_q_b, fwd_vld_reg, fwd_idx_reg,
                              fwd_data_reg, reg_vld_reg);

    lwalu_alu u_alu (
        .action (ex_action_reg),
        .src    (src_op),
        .left   (left_op),
        .cc_now (status_reg[lwalu_pkg::CC_W-1:0]),
        .res    (alu_res)
    );

    // Flags replace the low nibble; upper bits are kept.
    assign status_next = {status_reg[DW-1:lwalu_pkg::CC_W], alu_res.cc};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg  <= '0;
            reg_vld_reg <= '0;
            fwd_vld_reg <= 1'b0;
        end
        else if (ex_adv)
        begin
            status_reg <= status_next;
            if (alu_res.wr)
            begin
                reg_vld_reg[ex_dst_idx_reg] <= 1'b1;
                fwd_vld_reg                 <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ex_adv && alu_res.wr)
        begin
            fwd_idx_reg  <= ex_dst_idx_reg;
            fwd_data_reg <= alu_res.value;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (ex_adv)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ex_adv)
        begin
            out_value_reg  <= alu_res.value;
            out_cc_reg     <= alu_res.cc;
            out_status_reg <= status_next;
            out_wr_reg     <= alu_res.wr;
        end
    end

    assign result.valid        = out_vld_reg;
    assign result.result_value = out_value_reg;
    assign result.cond_codes   = out_cc_reg;
    assign result.status_word  = out_status_reg;
    assign result.reg_written  = out_wr_reg;

    // ---------------- assertions ----------------
    a_cc_in_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (out_status_reg[lwalu_pkg::CC_W-1:0] == out_cc_reg))
        else $error("result flags differ from status low nibble");

    a_bypass_tracks_write: assert property (@(posedge clk) disable iff (!rst_n)
        (ex_adv && alu_res.wr) |=> (fwd_vld_reg && (fwd_idx_reg == $past(ex_dst_idx_reg))
                                    && (fwd_data_reg == out_value_reg)))
        else $error("bypass register missed the last register write");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !instr.ready |-> (ex_vld_reg && out_vld_reg && !result.ready))
        else $error("instruction channel stalled with room in the pipeline");

endmodule

// ===== design/lwalu_ram.sv =====
// ----------------------------------------------------------------------------
// lwalu_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module lwalu_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]                      rd_data_a,
    input  logic                                  rd_en_b,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]                      rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en_a)
        begin
            rd_a_reg <= mem[rd_addr_a];
        end
        if (rd_en_b)
        begin
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

// ===== design/lwalu_alu.sv =====
// ----------------------------------------------------------------------------
// lwalu_alu
// Combinational ALU: result, NZVC flags and register-write decision.
// ----------------------------------------------------------------------------
module lwalu_alu (
    input  logic [lwalu_pkg::ACTION_W-1:0] action,
    input  logic [lwalu_pkg::DATA_W-1:0]   src,
    input  logic [lwalu_pkg::DATA_W-1:0]   left,
    input  logic [lwalu_pkg::CC_W-1:0]     cc_now,
    output lwalu_pkg::alu_res_t            res
);

    logic [lwalu_pkg::DATA_W:0]   sum_ext;
    logic [lwalu_pkg::DATA_W:0]   dif_ext;
    logic [lwalu_pkg::DATA_W-1:0] val;
    logic                         v_add;
    logic                         v_sub;
    localparam int unsigned MSB = lwalu_pkg::DATA_W - 1;

    assign sum_ext = {1'b0, left} + {1'b0, src};
    assign dif_ext = {1'b0, left} - {1'b0, src};

    // signed overflow
    assign v_add = (~(src[MSB] ^ left[MSB])) & (src[MSB] ^ sum_ext[MSB]);
    assign v_sub = (left[MSB] ^ src[MSB]) & (left[MSB] ^ dif_ext[MSB]);

    always_comb
    begin
        val         = '0;
        res.value   = '0;
        res.cc      = cc_now;
        res.wr      = 1'b0;
        res.defined = 1'b1;
        unique case (action) inside
            lwalu_pkg::ACT_ADD:
            begin
                val = sum_ext[MSB:0];
                res.cc[lwalu_pkg::CC_V_BIT] = v_add;
                res.cc[lwalu_pkg::CC_C_BIT] = sum_ext[lwalu_pkg::DATA_W];
                res.wr = 1'b1;
            end
            lwalu_pkg::ACT_SUB, lwalu_pkg::ACT_CMP:
            begin
                val = dif_ext[MSB:0];
                res.cc[lwalu_pkg::CC_V_BIT] = v_sub;
                res.cc[lwalu_pkg::CC_C_BIT] = dif_ext[lwalu_pkg::DATA_W];
                res.wr = (action == lwalu_pkg::ACT_SUB);
            end
            lwalu_pkg::ACT_OR,  lwalu_pkg::ACT_BIC, lwalu_pkg::ACT_XOR,
            lwalu_pkg::ACT_MOV, lwalu_pkg::ACT_COM, lwalu_pkg::ACT_TST:
            begin
                case (action)
                    lwalu_pkg::ACT_OR:  val = left | src;
                    lwalu_pkg::ACT_BIC: val = left & ~src;
                    lwalu_pkg::ACT_XOR: val = left ^ src;
                    lwalu_pkg::ACT_COM: val = ~src;
                    default:            val = src;
                endcase
                res.cc[lwalu_pkg::CC_V_BIT] = 1'b0;
                res.cc[lwalu_pkg::CC_C_BIT] = 1'b0;
                res.wr = (action != lwalu_pkg::ACT_TST);
            end
            default:
            begin
                // unknown opcode: nothing written, flags unchanged
                res.defined = 1'b0;
            end
        endcase
        if (res.defined)
        begin
            res.value = val;
            res.cc[lwalu_pkg::CC_N_BIT] = val[MSB];
            res.cc[lwalu_pkg::CC_Z_BIT] = (val == '0);
        end
    end

endmodule
